// ===== rtl/prfb_pkg.sv =====
// types and constants shared by the pipe ring fifo bank
package prfb_pkg;

  localparam logic [7:0] FD_BASE = 8'd32;
  localparam int unsigned FILL_W = 6;

  typedef enum logic [2:0] {
    CMD_ALLOC   = 3'd0,
    CMD_WRITE   = 3'd1,
    CMD_READ    = 3'd2,
    CMD_RELEASE = 3'd3,
    CMD_QUERY   = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BADFD   = 2'd1,
    ST_NOPIPE  = 2'd2,
    ST_REFUSED = 2'd3
  } status_t;

  typedef struct packed {
    status_t              status;
    logic [7:0]           new_read_fd;
    logic [FILL_W-1:0]    fill_level;
    logic [7:0]           moved_count;
  } res_t;

  typedef struct packed {
    status_t              status;
    logic [7:0]           read_byte;
    logic [7:0]           new_read_fd;
    logic [FILL_W-1:0]    fill_level;
    logic [7:0]           moved_count;
  } out_t;

endpackage

// ===== rtl/prfb_if.sv =====
// request and result channel interfaces of the pipe ring fifo bank
interface prfb_req_if
  import prfb_pkg::*;
;
  logic       valid;
  logic       ready;
  cmd_t       cmd;
  logic [7:0] fd;
  logic [7:0] data_byte;
  logic       last;

  modport source (output valid, cmd, fd, data_byte, last, input ready);
  modport sink   (input valid, cmd, fd, data_byte, last, output ready);
endinterface

interface prfb_res_if
  import prfb_pkg::*;
;
  logic              valid;
  logic              ready;
  status_t           status;
  logic [7:0]        read_byte;
  logic [7:0]        new_read_fd;
  logic [FILL_W-1:0] fill_level;
  logic [7:0]        moved_count;

  modport source (output valid, status, read_byte, new_read_fd, fill_level, moved_count,
                  input ready);
  modport sink   (input valid, status, read_byte, new_read_fd, fill_level, moved_count,
                  output ready);
endinterface

// ===== rtl/pipe_ring_fifo_bank.sv =====
// pipe ring fifo bank: descriptor decode, pointer state, byte store and result stages
// a result passes through the first result stage and then the output register after its request beat is taken
// throughput: one request beat per cycle while out_ch.ready does not stall the result stages
// reset: synchronous active-low rst_n clears pipe allocation, pointers, the moved
//   byte counter and the valid flags of both result stages; the byte store itself is not cleared
module pipe_ring_fifo_bank
  import prfb_pkg::*;
#(
  parameter int unsigned NUM_PIPES  = 8,
  parameter int unsigned FIFO_DEPTH = 64
) (
  input  logic          clk,
  input  logic          rst_n,
  prfb_req_if.sink      in_ch,
  prfb_res_if.source    out_ch
);

  localparam int unsigned PIPE_W    = (NUM_PIPES > 1) ? $clog2(NUM_PIPES) : 1;
  localparam int unsigned PTR_W     = $clog2(FIFO_DEPTH);
  localparam int unsigned SUM_W     = PTR_W + 7;
  localparam int unsigned MEM_DEPTH = NUM_PIPES * (2 ** PTR_W);

  logic [PTR_W-1:0]  head_r [NUM_PIPES];
  logic [PTR_W-1:0]  tail_r [NUM_PIPES];
  logic [NUM_PIPES-1:0] in_use_r;
  logic [7:0]        cnt_r, cnt_nxt;
  logic [7:0]        mem [MEM_DEPTH];
  logic [7:0]        rd_q_r;

  logic              s1_v_r;
  res_t              s1_r;
  logic              s1_rd_r;
  logic              out_v_r;
  out_t              out_r;

  logic              acc, s1_adv;
  logic [7:0]        fd_off;
  logic [6:0]        idx;
  logic [PIPE_W-1:0] pipe;
  logic              hit, odd;
  logic [PTR_W-1:0]  head, tail, head_nx, tail_nx;
  logic              free_found;
  logic [PIPE_W-1:0] free_idx;
  logic [SUM_W-1:0]  fsum;
  logic              do_alloc, do_wr, do_rd, do_rel;
  res_t              res_nxt;
  logic [7:0]        cnt_cur;

  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(FIFO_DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  assign acc    = in_ch.valid && in_ch.ready;
  assign s1_adv = s1_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready = !s1_v_r || s1_adv;

  // descriptor decode
  assign fd_off = in_ch.fd - FD_BASE;
  assign idx    = fd_off[7:1];
  assign pipe   = idx[PIPE_W-1:0];
  assign odd    = in_ch.fd[0];
  assign hit    = (in_ch.fd >= FD_BASE) && (idx < 7'(NUM_PIPES)) && in_use_r[pipe];

  assign head    = head_r[pipe];
  assign tail    = tail_r[pipe];
  assign head_nx = ring_next(head);
  assign tail_nx = ring_next(tail);

  always_comb begin
    if (head >= tail) begin
      fsum = SUM_W'(head) - SUM_W'(tail);
    end else begin
      fsum = SUM_W'(head) + SUM_W'(FIFO_DEPTH) - SUM_W'(tail);
    end
  end

  // lowest free pipe
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = NUM_PIPES - 1; i >= 0; i--) begin
      if (!in_use_r[i]) begin
        free_found = 1'b1;
        free_idx   = PIPE_W'(i);
      end
    end
  end

  always_comb begin
    do_alloc = 1'b0;
    do_wr    = 1'b0;
    do_rd    = 1'b0;
    do_rel   = 1'b0;
    res_nxt  = '{status: ST_BADFD, new_read_fd: '0, fill_level: '0, moved_count: '0};
    case (in_ch.cmd)
      CMD_ALLOC: begin
        if (free_found) begin
          do_alloc            = 1'b1;
          res_nxt.status      = ST_OK;
          res_nxt.new_read_fd = FD_BASE + 8'({free_idx, 1'b0});
        end else begin
          res_nxt.status = ST_NOPIPE;
        end
      end
      CMD_WRITE: begin
        if (hit && odd) begin
          if (head_nx == tail) begin
            res_nxt.status = ST_REFUSED;
          end else begin
            do_wr          = 1'b1;
            res_nxt.status = ST_OK;
          end
        end
      end
      CMD_READ: begin
        if (hit && !odd) begin
          if (head == tail) begin
            res_nxt.status = ST_REFUSED;
          end else begin
            do_rd          = 1'b1;
            res_nxt.status = ST_OK;
          end
        end
      end
      CMD_RELEASE: begin
        if (hit) begin
          do_rel         = 1'b1;
          res_nxt.status = ST_OK;
        end
      end
      CMD_QUERY: begin
        if (hit) begin
          res_nxt.status     = ST_OK;
          res_nxt.fill_level = fsum[FILL_W-1:0];
        end
      end
      default: begin
        res_nxt.status = ST_BADFD;
      end
    endcase
    cnt_cur = ((do_wr || do_rd) && (cnt_r != 8'hFF)) ? cnt_r + 8'd1 : cnt_r;
    res_nxt.moved_count = cnt_cur;
    cnt_nxt = in_ch.last ? 8'd0 : cnt_cur;
  end

  // pipe state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_use_r <= '0;
      cnt_r    <= '0;
      for (int i = 0; i < NUM_PIPES; i++) begin
        head_r[i] <= '0;
        tail_r[i] <= '0;
      end
    end else if (acc) begin
      cnt_r <= cnt_nxt;
      if (do_alloc) begin
        in_use_r[free_idx] <= 1'b1;
        head_r[free_idx]   <= '0;
        tail_r[free_idx]   <= '0;
      end
      if (do_rel) begin
        in_use_r[pipe] <= 1'b0;
      end
      if (do_wr) begin
        head_r[pipe] <= head_nx;
      end
      if (do_rd) begin
        tail_r[pipe] <= tail_nx;
      end
    end
  end

  // byte store
  always_ff @(posedge clk) begin
    if (acc && do_wr) begin
      mem[{pipe, head}] <= in_ch.data_byte;
    end
    if (acc && do_rd) begin
      rd_q_r <= mem[{pipe, tail}];
    end
  end

  // first result stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (acc) begin
      s1_v_r <= 1'b1;
    end else if (s1_adv) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_r    <= res_nxt;
      s1_rd_r <= do_rd;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s1_adv) begin
      out_v_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_r.status      <= s1_r.status;
      out_r.read_byte   <= s1_rd_r ? rd_q_r : 8'd0;
      out_r.new_read_fd <= s1_r.new_read_fd;
      out_r.fill_level  <= s1_r.fill_level;
      out_r.moved_count <= s1_r.moved_count;
    end
  end

  assign out_ch.valid       = out_v_r;
  assign out_ch.status      = out_r.status;
  assign out_ch.read_byte   = out_r.read_byte;
  assign out_ch.new_read_fd = out_r.new_read_fd;
  assign out_ch.fill_level  = out_r.fill_level;
  assign out_ch.moved_count = out_r.moved_count;

  a_full_alloc: assert property (@(posedge clk) disable iff (!rst_n)
    acc && (in_ch.cmd == CMD_ALLOC) && (&in_use_r) |=> s1_r.status == ST_NOPIPE)
    else $error("allocate with every pipe in use did not report no free pipe");

  a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && (s1_r.status != ST_OK) |-> !s1_rd_r && (s1_r.fill_level == '0) &&
      (s1_r.new_read_fd == '0))
    else $error("failed beat carries read, fill or descriptor data");

  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && !s1_adv |=> s1_v_r && $stable(s1_r) && (!s1_rd_r || $stable(rd_q_r)))
    else $error("held result stage changed while the output was stalled");

  a_count_reset: assert property (@(posedge clk) disable iff (!rst_n)
    acc && in_ch.last |=> cnt_r == 8'd0)
    else $error("moved byte counter did not restart after a last beat");

endmodule

// ===== test/testbench.sv =====
// self-checking testbench for the pipe ring fifo bank with a directed table and random traffic
`timescale 1ns / 100ps

module testbench;
  import prfb_pkg::*;

  localparam int NUM_PIPES    = 8;
  localparam int FIFO_DEPTH   = 64;
  localparam int CLK_PERIOD   = 2;
  localparam int RESET_CYCLES = 9;
  localparam int RANDOM_BEATS = 700;
  localparam int LONG_PAIRS   = 130;
  localparam int DRAIN_CYCLES = 8;
  localparam int MAX_REPORTS  = 50;
  localparam int TIMEOUT_NS   = 1_000_000;

  localparam logic [2:0] CMD_RSVD_LO = 3'd5;
  localparam logic [2:0] CMD_RSVD_HI = 3'd7;

  typedef struct {
    logic [2:0] cmd;
    logic [7:0] fd;
    logic [7:0] data;
    logic       last;
    bit         typed;
    out_t       want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;

  prfb_req_if req_ch ();
  prfb_res_if res_ch ();

  pipe_ring_fifo_bank #(
    .NUM_PIPES  (NUM_PIPES),
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (req_ch),
    .out_ch (res_ch)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  bit         pipe_busy [NUM_PIPES] = '{default: 1'b0};
  int         wr_ptr    [NUM_PIPES] = '{default: 0};
  int         rd_ptr    [NUM_PIPES] = '{default: 0};
  logic [7:0] byte_mem  [NUM_PIPES * FIFO_DEPTH];
  logic [7:0] moved_bytes = '0;

  out_t pending_results [$];
  out_t oldest_result;
  int   fail_count  = 0;
  int   beats_taken = 0;
  int   burst_left  = 0;
  int   stall_mode  = 0;
  int   stall_left  = 0;

  function automatic out_t fifo_bank_step(input logic [2:0] c, input logic [7:0] fd,
                                          input logic [7:0] d, input logic l);
    out_t r;
    int   p;
    int   i;
    int   base;
    int   nxt;
    bit   moved;
    r        = '0;
    r.status = ST_BADFD;
    moved    = 1'b0;
    p        = (fd < FD_BASE) ? -1 : int'((fd - FD_BASE) >> 1);
    if (p >= NUM_PIPES) p = -1;
    if (c == CMD_ALLOC) begin
      r.status = ST_NOPIPE;
      for (i = 0; i < NUM_PIPES && r.status == ST_NOPIPE; i++) begin
        if (!pipe_busy[i]) begin
          pipe_busy[i]  = 1'b1;
          wr_ptr[i]     = 0;
          rd_ptr[i]     = 0;
          r.new_read_fd = 8'(FD_BASE + 2 * i);
          r.status      = ST_OK;
        end
      end
    end else if (c <= CMD_QUERY && p >= 0 && pipe_busy[p]) begin
      base = p * FIFO_DEPTH;
      case (c)
        CMD_WRITE: begin
          if (fd[0]) begin
            nxt = (wr_ptr[p] + 1) % FIFO_DEPTH;
            if (nxt == rd_ptr[p]) begin
              r.status = ST_REFUSED;
            end else begin
              byte_mem[base + wr_ptr[p]] = d;
              wr_ptr[p] = nxt;
              moved     = 1'b1;
              r.status  = ST_OK;
            end
          end
        end
        CMD_READ: begin
          if (!fd[0]) begin
            if (rd_ptr[p] == wr_ptr[p]) begin
              r.status = ST_REFUSED;
            end else begin
              r.read_byte = byte_mem[base + rd_ptr[p]];
              rd_ptr[p]   = (rd_ptr[p] + 1) % FIFO_DEPTH;
              moved       = 1'b1;
              r.status    = ST_OK;
            end
          end
        end
        CMD_RELEASE: begin
          pipe_busy[p] = 1'b0;
          r.status     = ST_OK;
        end
        default: begin
          r.fill_level = FILL_W'((wr_ptr[p] + FIFO_DEPTH - rd_ptr[p]) % FIFO_DEPTH);
          r.status     = ST_OK;
        end
      endcase
    end
    if (moved && moved_bytes != 8'hFF) moved_bytes++;
    r.moved_count = moved_bytes;
    if (l) moved_bytes = '0;
    return r;
  endfunction

  function automatic stim_row_t pred_row(input logic [2:0] c, input logic [7:0] fd,
                                         input logic [7:0] d, input logic l);
    stim_row_t r;
    r.cmd   = c;
    r.fd    = fd;
    r.data  = d;
    r.last  = l;
    r.typed = 1'b0;
    r.want  = '0;
    return r;
  endfunction

  function automatic stim_row_t known_row(input logic [2:0] c, input logic [7:0] fd,
                                          input logic [7:0] d, input logic l,
                                          input status_t st, input logic [7:0] nfd);
    stim_row_t r;
    r                  = pred_row(c, fd, d, l);
    r.typed            = 1'b1;
    r.want.status      = st;
    r.want.new_read_fd = nfd;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want_v);
    if (fail_count < MAX_REPORTS)
      $display("%0t: %s mismatch, got %0d expected %0d", $time, what, got, want_v);
    fail_count++;
  endtask

  // one request beat, with a random gap, possibly none, opening each burst
  task automatic send_req(input stim_row_t row);
    out_t predicted;
    int   idle;
    if (burst_left == 0) begin
      idle = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (idle != 0) begin
        req_ch.valid <= 1'b0;
        repeat (idle) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    req_ch.valid     <= 1'b1;
    req_ch.cmd       <= cmd_t'(row.cmd);
    req_ch.fd        <= row.fd;
    req_ch.data_byte <= row.data;
    req_ch.last      <= row.last;
    do @(posedge clk); while (!req_ch.ready);
    burst_left--;
    beats_taken++;
    predicted = fifo_bank_step(row.cmd, row.fd, row.data, row.last);
    pending_results.push_back(row.typed ? row.want : predicted);
  endtask

  initial begin
    res_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_left = $urandom_range(16, 96);
      end
      stall_left--;
      case (stall_mode)
        0:       res_ch.ready <= 1'b1;
        1:       res_ch.ready <= stall_left[0];
        2:       res_ch.ready <= ($urandom_range(0, 3) != 0);
        default: res_ch.ready <= ((stall_left % 8) < 3);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n && res_ch.valid && res_ch.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result beat", int'(res_ch.status), -1);
      end else begin
        oldest_result = pending_results.pop_front();
        if (res_ch.status != oldest_result.status)
          report_mismatch("status", int'(res_ch.status), int'(oldest_result.status));
        if (res_ch.read_byte != oldest_result.read_byte)
          report_mismatch("read_byte", res_ch.read_byte, oldest_result.read_byte);
        if (res_ch.new_read_fd != oldest_result.new_read_fd)
          report_mismatch("new_read_fd", res_ch.new_read_fd, oldest_result.new_read_fd);
        if (res_ch.fill_level != oldest_result.fill_level)
          report_mismatch("fill_level", res_ch.fill_level, oldest_result.fill_level);
        if (res_ch.moved_count != oldest_result.moved_count)
          report_mismatch("moved_count", res_ch.moved_count, oldest_result.moved_count);
      end
    end
  end

  initial begin
    stim_row_t directed [$];
    int        i;
    int        k;
    int        n;
    int        p;
    int        pick;
    int        random_start;
    logic      l;

    rst_n            = 1'b0;
    req_ch.valid     = 1'b0;
    req_ch.cmd       = CMD_ALLOC;
    req_ch.fd        = '0;
    req_ch.data_byte = '0;
    req_ch.last      = 1'b0;

    directed = '{
      known_row(CMD_QUERY,   8'd32,  8'h00, 1'b0, ST_BADFD,   8'd0),
      known_row(CMD_ALLOC,   8'hFF,  8'h00, 1'b0, ST_OK,      8'd32),
      known_row(CMD_WRITE,   8'd32,  8'hA5, 1'b0, ST_BADFD,   8'd0),
      known_row(CMD_READ,    8'd32,  8'h00, 1'b0, ST_REFUSED, 8'd0),
      pred_row (CMD_WRITE,   8'd33,  8'h00, 1'b0),
      pred_row (CMD_WRITE,   8'd33,  8'hFF, 1'b1),
      pred_row (CMD_QUERY,   8'd32,  8'h00, 1'b0),
      known_row(CMD_READ,    8'd33,  8'h00, 1'b0, ST_BADFD,   8'd0),
      pred_row (CMD_READ,    8'd32,  8'h00, 1'b0),
      pred_row (CMD_READ,    8'd32,  8'h00, 1'b1),
      known_row(CMD_QUERY,   8'd0,   8'h00, 1'b0, ST_BADFD,   8'd0),
      known_row(CMD_WRITE,   8'd31,  8'h5A, 1'b0, ST_BADFD,   8'd0),
      known_row(CMD_QUERY,   8'd48,  8'h00, 1'b0, ST_BADFD,   8'd0),
      known_row(CMD_WRITE,   8'd255, 8'hFF, 1'b1, ST_BADFD,   8'd0),
      known_row(CMD_RSVD_LO, 8'd32,  8'h00, 1'b0, ST_BADFD,   8'd0),
      known_row(CMD_RSVD_HI, 8'd33,  8'hFF, 1'b1, ST_BADFD,   8'd0),
      known_row(CMD_RELEASE, 8'd40,  8'h00, 1'b0, ST_BADFD,   8'd0),
      pred_row (CMD_ALLOC,   8'd0,   8'h00, 1'b0),
      pred_row (CMD_ALLOC,   8'd0,   8'h00, 1'b0),
      pred_row (CMD_ALLOC,   8'd0,   8'h00, 1'b0),
      pred_row (CMD_ALLOC,   8'd0,   8'h00, 1'b0),
      pred_row (CMD_ALLOC,   8'd0,   8'h00, 1'b0),
      pred_row (CMD_ALLOC,   8'd0,   8'h00, 1'b0),
      pred_row (CMD_ALLOC,   8'd0,   8'h00, 1'b0),
      known_row(CMD_ALLOC,   8'd0,   8'h00, 1'b1, ST_NOPIPE,  8'd0),
      pred_row (CMD_RELEASE, 8'd35,  8'h00, 1'b0),
      pred_row (CMD_ALLOC,   8'd0,   8'h00, 1'b0)
    };

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed[i]) send_req(directed[i]);

    // one long call on pipe 0 that drives the moved counter into saturation
    for (i = 0; i < LONG_PAIRS; i++) begin
      send_req(pred_row(CMD_WRITE, 8'd33, 8'($urandom), 1'b0));
      send_req(pred_row(CMD_READ, 8'd32, 8'h00, i == LONG_PAIRS - 1));
    end

    random_start = beats_taken;
    while (beats_taken < random_start + RANDOM_BEATS) begin
      pick = $urandom_range(0, 9);
      p    = $urandom_range(0, NUM_PIPES - 1);
      for (k = 0; k < NUM_PIPES && !pipe_busy[p]; k++) p = (p + 1) % NUM_PIPES;
      case (pick)
        0, 1: begin
          send_req(pred_row(CMD_ALLOC, 8'($urandom), 8'($urandom), 1'($urandom)));
        end
        2, 3, 4: begin
          n = $urandom_range(1, 70);
          for (i = 0; i < n; i++) begin
            l = (i == n - 1) ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 15) == 0);
            send_req(pred_row(CMD_WRITE, 8'(FD_BASE + 2 * p + 1), 8'($urandom), l));
          end
        end
        5, 6: begin
          n = $urandom_range(1, 70);
          for (i = 0; i < n; i++) begin
            l = (i == n - 1) ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 15) == 0);
            send_req(pred_row(CMD_READ, 8'(FD_BASE + 2 * p), 8'($urandom), l));
          end
        end
        7: begin
          send_req(pred_row(CMD_RELEASE, 8'(FD_BASE + 2 * p + $urandom_range(0, 1)),
                            8'($urandom), 1'($urandom)));
        end
        8: begin
          send_req(pred_row(CMD_QUERY, 8'(FD_BASE + $urandom_range(0, 2 * NUM_PIPES - 1)),
                            8'($urandom), 1'($urandom)));
        end
        default: begin
          // noise beats across the whole field range
          for (i = 0; i < 8; i++)
            send_req(pred_row(3'($urandom), 8'($urandom), 8'($urandom), 1'($urandom)));
        end
      endcase
    end

    req_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("%0t: timeout with %0d results pending", $time, pending_results.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/prfb_pkg.sv
rtl/prfb_if.sv
rtl/pipe_ring_fifo_bank.sv
test/testbench.sv
